// ===== src/complex_arithmetic_unit_top_macros.svh =====
// Assertion macros for the complex arithmetic unit
`ifndef COMPLEX_ARITHMETIC_UNIT_TOP_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_TOP_MACROS_SVH
`ifndef SYNTH
`define CAU_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CAU_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CAU_ASSERT_IMPL(label, clk, rst, ante, cons)
`define CAU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== src/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg
// Types and operation codes shared by the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;
  localparam int DW = 16;
  localparam int FB = 8;
  localparam int NUM_W = 2 * DW + FB + 2;  // shifted numerator magnitude
  localparam int DEN_W = 2 * DW + 1;       // |b|^2
  localparam int QW = NUM_W + 1;           // quotient register width

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  typedef struct packed {
    logic [1:0]           req_type;
    logic signed [DW-1:0] a_re;
    logic signed [DW-1:0] a_im;
    logic signed [DW-1:0] b_re;
    logic signed [DW-1:0] b_im;
  } req_t;

  typedef struct packed {
    logic signed [DW-1:0] res_re;
    logic signed [DW-1:0] res_im;
    logic                 overflow;
    logic                 div_by_zero;
  } res_t;

  // one request travelling down the divider chain
  typedef struct packed {
    logic             valid;
    logic             is_div;
    logic             dz;
    logic             neg_re;
    logic             neg_im;
    logic [NUM_W-1:0] rem_re;  // partial remainder, top bits consumed
    logic [NUM_W-1:0] rem_im;
    logic [NUM_W-1:0] num_re;  // numerator bits still to shift in
    logic [NUM_W-1:0] num_im;
    logic [DEN_W-1:0] den;
    logic [QW-1:0]    q_re;
    logic [QW-1:0]    q_im;
  } lane_t;
endpackage

// ===== src/cau_front.sv =====
// ----------------------------------------------------------------------------
// cau_front
// Forms products and sums, registers them, feeds the divider chain.
// ----------------------------------------------------------------------------
module cau_front (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  cau_pkg::req_t req,
  output cau_pkg::lane_t lane
);
  import cau_pkg::*;

  logic v1;
  logic [1:0] op1;
  logic signed [2*DW-1:0] p_rr, p_ii, p_ri, p_ir, p_br, p_bi;
  logic signed [DW:0] s_re, s_im;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= in_valid;
    op1 <= req.req_type;
    p_rr <= req.a_re * req.b_re;
    p_ii <= req.a_im * req.b_im;
    p_ri <= req.a_re * req.b_im;
    p_ir <= req.a_im * req.b_re;
    p_br <= req.b_re * req.b_re;
    p_bi <= req.b_im * req.b_im;
    s_re <= (req.req_type == OP_SUB) ? ({req.a_re[DW-1], req.a_re} - {req.b_re[DW-1], req.b_re})
                                     : ({req.a_re[DW-1], req.a_re} + {req.b_re[DW-1], req.b_re});
    s_im <= (req.req_type == OP_SUB) ? ({req.a_im[DW-1], req.a_im} - {req.b_im[DW-1], req.b_im})
                                     : ({req.a_im[DW-1], req.a_im} + {req.b_im[DW-1], req.b_im});
  end

  logic signed [2*DW+1:0] t_re, t_im, v_re, v_im;
  logic [DEN_W-1:0] den;
  logic [NUM_W-1:0] m_re, m_im;

  always_comb begin
    lane = '0;
    v_re = '0;
    v_im = '0;
    den = {1'b0, p_br} + {1'b0, p_bi};
    unique case (op1)
      OP_ADD, OP_SUB: begin
        v_re = (2*DW+2)'(s_re);
        v_im = (2*DW+2)'(s_im);
      end
      OP_MUL: begin
        t_re = (2*DW+2)'(p_rr) - (2*DW+2)'(p_ii);
        t_im = (2*DW+2)'(p_ri) + (2*DW+2)'(p_ir);
        v_re = t_re >>> FB;
        v_im = t_im >>> FB;
      end
      default: begin
        v_re = (2*DW+2)'(p_rr) + (2*DW+2)'(p_ii);
        v_im = (2*DW+2)'(p_ir) - (2*DW+2)'(p_ri);
      end
    endcase
    t_re = '0;
    t_im = '0;
    m_re = NUM_W'(v_re[2*DW+1] ? -v_re : v_re);
    m_im = NUM_W'(v_im[2*DW+1] ? -v_im : v_im);
    lane.valid = v1;
    lane.neg_re = v_re[2*DW+1];
    lane.neg_im = v_im[2*DW+1];
    lane.den = den;
    if (op1 == OP_DIV) begin
      lane.is_div = 1'b1;
      lane.dz = (den == '0);
      lane.num_re = m_re << FB;
      lane.num_im = m_im << FB;
    end else begin
      lane.q_re = QW'(m_re);
      lane.q_im = QW'(m_im);
    end
  end
endmodule

// ===== src/cau_cell.sv =====
// ----------------------------------------------------------------------------
// cau_cell
// One restoring division step per cell for both parts; passes others through.
// ----------------------------------------------------------------------------
module cau_cell (
  input  logic           clk,
  input  logic           rst,
  input  cau_pkg::lane_t lane_in,
  output cau_pkg::lane_t lane_out
);
  import cau_pkg::*;

  cau_pkg::lane_t lane_next;
  logic [NUM_W:0] tr, ti;

  always_comb begin
    lane_next = lane_in;
    tr = {lane_in.rem_re, lane_in.num_re[NUM_W-1]};
    ti = {lane_in.rem_im, lane_in.num_im[NUM_W-1]};
    if (lane_in.is_div) begin
      lane_next.num_re = lane_in.num_re << 1;
      lane_next.num_im = lane_in.num_im << 1;
      if (tr >= {{(NUM_W-DEN_W+1){1'b0}}, lane_in.den}) begin
        lane_next.rem_re = NUM_W'(tr - {{(NUM_W-DEN_W+1){1'b0}}, lane_in.den});
        lane_next.q_re = {lane_in.q_re[QW-2:0], 1'b1};
      end else begin
        lane_next.rem_re = NUM_W'(tr);
        lane_next.q_re = {lane_in.q_re[QW-2:0], 1'b0};
      end
      if (ti >= {{(NUM_W-DEN_W+1){1'b0}}, lane_in.den}) begin
        lane_next.rem_im = NUM_W'(ti - {{(NUM_W-DEN_W+1){1'b0}}, lane_in.den});
        lane_next.q_im = {lane_in.q_im[QW-2:0], 1'b1};
      end else begin
        lane_next.rem_im = NUM_W'(ti);
        lane_next.q_im = {lane_in.q_im[QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) lane_out <= '0;
    else lane_out <= lane_next;
  end
endmodule

// ===== src/cau_sat.sv =====
// ----------------------------------------------------------------------------
// cau_sat
// Applies sign, zero-divisor rule and saturation; registers the result.
// ----------------------------------------------------------------------------
module cau_sat (
  input  logic           clk,
  input  logic           rst,
  input  cau_pkg::lane_t lane,
  output logic           done,
  output cau_pkg::res_t  res
);
  import cau_pkg::*;

  localparam logic [QW-1:0] POS_MAX = QW'((1 << (DW - 1)) - 1);
  localparam logic [QW-1:0] NEG_MAX = QW'(1 << (DW - 1));

  logic ov_re, ov_im;
  logic [DW-1:0] m_re, m_im;

  always_comb begin
    ov_re = lane.neg_re ? (lane.q_re > NEG_MAX) : (lane.q_re > POS_MAX);
    ov_im = lane.neg_im ? (lane.q_im > NEG_MAX) : (lane.q_im > POS_MAX);
    m_re = ov_re ? NEG_MAX[DW-1:0] - DW'(!lane.neg_re) : lane.q_re[DW-1:0];
    m_im = ov_im ? NEG_MAX[DW-1:0] - DW'(!lane.neg_im) : lane.q_im[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= lane.valid;
    if (lane.dz) begin
      res.res_re <= '0;
      res.res_im <= '0;
      res.overflow <= 1'b0;
      res.div_by_zero <= 1'b1;
    end else begin
      res.res_re <= lane.neg_re ? -m_re : m_re;
      res.res_im <= lane.neg_im ? -m_im : m_im;
      res.overflow <= ov_re | ov_im;
      res.div_by_zero <= 1'b0;
    end
  end
endmodule

// ===== src/complex_arithmetic_unit_top.sv =====
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_top
// Complex add, subtract, multiply and divide on signed Q8.8 operands.
// ----------------------------------------------------------------------------
// A request is taken on any edge where start is high; busy is always low,
// so one request may follow every cycle. Each request gives one result on
// result, marked by done for a single cycle. The receiver cannot stall.
// Every operation takes the same path from the accepting edge to the edge
// that takes the result: one product and sum register
// stage, a chain of 42 division cells (one quotient bit per cell, both
// parts in parallel), and a saturation register.
// Non-divide requests ride the chain unchanged to keep order.
// Throughput: one request per cycle.
// Reset clears all valid bits in the chain; requests in flight are dropped.
// ----------------------------------------------------------------------------
`include "complex_arithmetic_unit_top_macros.svh"
module complex_arithmetic_unit_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  cau_pkg::req_t req,
  output logic          done,
  output cau_pkg::res_t result
);
  import cau_pkg::*;

  lane_t chain [NUM_W+1];

  assign busy = 1'b0;

  cau_front u_front (
    .clk(clk), .rst(rst), .in_valid(start & ~busy), .req(req), .lane(chain[0])
  );

  for (genvar i = 0; i < NUM_W; i++) begin : g_cell
    cau_cell u_cell (.clk(clk), .rst(rst), .lane_in(chain[i]), .lane_out(chain[i+1]));
  end

  cau_sat u_sat (
    .clk(clk), .rst(rst), .lane(chain[NUM_W]), .done(done), .res(result)
  );

  `CAU_ASSERT_IMPL(a_dz_zero, clk, rst, done && result.div_by_zero,
    result.res_re == '0 && result.res_im == '0 && !result.overflow)
  `CAU_ASSERT_IMPL(a_dz_only_div, clk, rst, chain[NUM_W].valid && !chain[NUM_W].is_div,
    !chain[NUM_W].dz)
  `CAU_ASSERT_NEXT(a_done_follows, clk, rst, chain[NUM_W].valid, done)
endmodule

// ===== tb/sv/complex_arithmetic_unit_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_top_test
// Drives add, subtract, multiply and divide requests with random spacing and
// checks every result against a local fixed-point predictor, in order.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_top_test;
  import cau_pkg::*;

  localparam int LATENCY = 45;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t req = '0;
  logic done;
  res_t result;

  req_t pending_q[$];
  res_t expected_q[$];
  int sender_idle_pct = 16;
  bit hold_off = 1'b0;
  bit stim_done = 1'b0;
  int mismatches = 0;
  int n_results = 0;
  int n_requests = 0;
  int n_ovf = 0;
  int n_dz = 0;

  complex_arithmetic_unit_top u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // saturate an exact value into the signed 16-bit range
  function automatic logic signed [DW-1:0] clamp(input logic signed [127:0] v,
                                                 inout logic ovf);
    if (v > 128'sd32767) begin
      ovf = 1'b1;
      return 16'sh7fff;
    end else if (v < -128'sd32768) begin
      ovf = 1'b1;
      return 16'sh8000;
    end
    return v[DW-1:0];
  endfunction

  // truncating divide of (num << FB) by den, den > 0
  function automatic logic signed [127:0] div_trunc(input logic signed [127:0] num,
                                                    input logic signed [127:0] den);
    logic signed [127:0] mag;
    logic signed [127:0] q;
    mag = (num < 0) ? -num : num;
    q = (mag <<< FB) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic res_t complex_result(input req_t r);
    logic signed [127:0] ar, ai, br, bi, re, im, den;
    res_t o;
    logic ovf;
    ar = r.a_re; ai = r.a_im; br = r.b_re; bi = r.b_im;
    ovf = 1'b0;
    o = '0;
    re = 0;
    im = 0;
    case (r.req_type)
      OP_ADD: begin
        re = ar + br; im = ai + bi;
      end
      OP_SUB: begin
        re = ar - br; im = ai - bi;
      end
      OP_MUL: begin
        re = (ar * br - ai * bi) >>> FB;
        im = (ar * bi + ai * br) >>> FB;
      end
      default: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          o.div_by_zero = 1'b1;
        end else begin
          re = div_trunc(ar * br + ai * bi, den);
          im = div_trunc(ai * br - ar * bi, den);
        end
      end
    endcase
    o.res_re = clamp(re, ovf);
    o.res_im = clamp(im, ovf);
    o.overflow = ovf;
    return o;
  endfunction

  function automatic logic [DW-1:0] rand_part();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($signed($urandom_range(0, 1023)) - 512);
      3: return 16'($signed($urandom_range(0, 15)) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_request(input logic [1:0] op, input logic [DW-1:0] ar,
                             input logic [DW-1:0] ai, input logic [DW-1:0] br,
                             input logic [DW-1:0] bi);
    req_t r;
    r.req_type = op; r.a_re = ar; r.a_im = ai; r.b_re = br; r.b_im = bi;
    pending_q.push_back(r);
  endtask

  // driver: one request per accepted edge, random idle cycles
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_q.push_back(complex_result(req));
        n_requests++;
      end
      if (!(start && busy)) begin
        if (pending_q.size() > 0 && !hold_off &&
            $urandom_range(0, 99) >= sender_idle_pct) begin
          req <= pending_q.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      n_results++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result with no request outstanding");
      end else begin
        res_t e;
        e = expected_q.pop_front();
        if (e.overflow) n_ovf++;
        if (e.div_by_zero) n_dz++;
        if (result !== e) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: exp re=%h im=%h ov=%b dz=%b got re=%h im=%h ov=%b dz=%b",
                     e.res_re, e.res_im, e.overflow, e.div_by_zero, result.res_re,
                     result.res_im, result.overflow, result.div_by_zero);
        end
      end
    end
  end

  task automatic drain();
    while (pending_q.size() > 0 || start) @(posedge clk);
    while (expected_q.size() > 0) @(posedge clk);
  endtask

  task automatic random_requests(input int n);
    logic [1:0] op;
    for (int i = 0; i < n; i++) begin
      op = 2'($urandom_range(0, 3));
      add_request(op, rand_part(), rand_part(), rand_part(), rand_part());
      // occasionally a zero divisor
      if (op == OP_DIV && $urandom_range(0, 9) == 0) begin
        pending_q[$].b_re = '0;
        pending_q[$].b_im = '0;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // directed: extremes, each operation, zero divisor, saturation
    add_request(OP_ADD, 16'h0100, 16'h0200, 16'h0300, 16'hff00);
    add_request(OP_ADD, 16'h7fff, 16'h8000, 16'h0001, 16'hffff);
    add_request(OP_SUB, 16'h8000, 16'h7fff, 16'h0001, 16'hffff);
    add_request(OP_SUB, 16'h0000, 16'h0000, 16'h8000, 16'h8000);
    add_request(OP_MUL, 16'h0100, 16'h0100, 16'h0100, 16'hff00);
    add_request(OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    add_request(OP_MUL, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff);
    add_request(OP_MUL, 16'hffff, 16'h0000, 16'h0001, 16'h0000);
    add_request(OP_DIV, 16'h0100, 16'h0000, 16'h0000, 16'h0000);
    add_request(OP_DIV, 16'h0200, 16'h0100, 16'h0100, 16'h0000);
    add_request(OP_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000);
    add_request(OP_DIV, 16'h8000, 16'h8000, 16'h0000, 16'hffff);
    add_request(OP_DIV, 16'hffff, 16'h0001, 16'h7fff, 16'h8000);
    add_request(OP_DIV, 16'h0001, 16'hffff, 16'h8000, 16'h8000);
    add_request(OP_DIV, 16'hffff, 16'h0000, 16'h0300, 16'h0000);
    random_requests(130);
    drain();
    // hold the sender until the pipeline is empty
    hold_off = 1'b1;
    random_requests(5);
    drain_hold: while (expected_q.size() > 0) @(posedge clk);
    hold_off = 1'b0;
    drain();
    sender_idle_pct = 61;
    random_requests(130);
    drain();
    sender_idle_pct = 0;
    random_requests(130);
    drain();
    repeat (LATENCY + 10) @(posedge clk);
    $display("Covered %0d requests, %0d results; %0d saturated, %0d divide-by-zero.",
             n_requests, n_results, n_ovf, n_dz);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Mismatches: %0d, outstanding: %0d", mismatches, expected_q.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Timeout");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+src
src/cau_pkg.sv
src/cau_front.sv
src/cau_cell.sv
src/cau_sat.sv
src/complex_arithmetic_unit_top.sv
tb/sv/complex_arithmetic_unit_top_test.sv
